// ===== design/eues_pkg.sv =====
`default_nettype none
package eues_pkg;
  localparam int CORDIC_ITERATIONS_DEF = 16;
  localparam int FRAC_BITS_DEF = 16;
  localparam int ATAN_ENTRIES = 30;
  localparam logic signed [35:0] PI_Q30 = 36'sd3373259426;
  localparam logic signed [35:0] HALF_PI_Q30 = 36'sd1686629713;
  localparam logic signed [35:0] TWO_PI_Q30 = 36'sd6746518852;
  localparam logic signed [35:0] GAIN_Q30 = 36'sd652032874;
  // 2^64 divided by the two pi constant above, rounded.
  localparam logic [31:0] INV_TWO_PI_Q64 = 32'd2734261102;

  localparam logic [2:0] REG_STEP_TIME = 3'd0;
  localparam logic [2:0] REG_INIT_X = 3'd1;
  localparam logic [2:0] REG_INIT_Y = 3'd2;
  localparam logic [2:0] REG_INIT_HD = 3'd3;
  localparam logic [2:0] REG_INIT_SP = 3'd4;
  localparam logic [2:0] REG_INIT_TR = 3'd5;

  typedef enum logic [3:0] {
    ST_IDLE, ST_LOAD, ST_REMAIN, ST_REDUCE, ST_FOLD, ST_CORDIC, ST_MUL1, ST_MUL2,
    ST_MUL3, ST_MUL4, ST_MUL5, ST_MUL6, ST_COMMIT, ST_OUT
  } state_t;

  typedef struct packed {
    logic load;
    logic remain;
    logic reduce;
    logic fold;
    logic cordic;
    logic [2:0] mul_step;
    logic mul_en;
    logic commit;
  } cmd_t;

  typedef struct packed {
    logic reduce_done;
  } stat_t;

  function automatic logic signed [35:0] atan_q30(input logic [4:0] i);
    logic signed [35:0] r;
    case (i)
      5'd0: r = 36'sd843314856;   5'd1: r = 36'sd497837829;
      5'd2: r = 36'sd263043836;   5'd3: r = 36'sd133525158;
      5'd4: r = 36'sd67021686;    5'd5: r = 36'sd33543515;
      5'd6: r = 36'sd16775850;    5'd7: r = 36'sd8388437;
      5'd8: r = 36'sd4194282;     5'd9: r = 36'sd2097149;
      5'd10: r = 36'sd1048575;    5'd11: r = 36'sd524287;
      5'd12: r = 36'sd262143;     5'd13: r = 36'sd131071;
      5'd14: r = 36'sd65535;      5'd15: r = 36'sd32767;
      5'd16: r = 36'sd16383;      5'd17: r = 36'sd8191;
      5'd18: r = 36'sd4095;       5'd19: r = 36'sd2047;
      5'd20: r = 36'sd1023;       5'd21: r = 36'sd511;
      5'd22: r = 36'sd255;        5'd23: r = 36'sd127;
      5'd24: r = 36'sd63;         5'd25: r = 36'sd31;
      5'd26: r = 36'sd15;         5'd27: r = 36'sd7;
      5'd28: r = 36'sd3;          5'd29: r = 36'sd1;
      default: r = '0;
    endcase
    return r;
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [33:0] v);
    if (v > 34'sd2147483647) return 32'sh7fffffff;
    if (v < -34'sd2147483648) return 32'sh80000000;
    return v[31:0];
  endfunction
endpackage
`default_nettype wire

// ===== design/eues_if.sv =====
`default_nettype none
interface eues_in_if;
  logic valid;
  logic ready;
  logic restart;
  logic signed [31:0] lin_accel;
  logic signed [31:0] ang_accel;
  modport source (output valid, restart, lin_accel, ang_accel, input ready);
  modport sink (input valid, restart, lin_accel, ang_accel, output ready);
endinterface

interface eues_out_if;
  logic valid;
  logic ready;
  logic signed [31:0] new_x;
  logic signed [31:0] new_y;
  logic signed [31:0] new_heading;
  logic signed [31:0] new_speed;
  logic signed [31:0] new_turn_rate;
  modport source (output valid, new_x, new_y, new_heading, new_speed, new_turn_rate,
                  input ready);
  modport sink (input valid, new_x, new_y, new_heading, new_speed, new_turn_rate,
                output ready);
endinterface

interface eues_cfg_if;
  logic valid;
  logic ready;
  logic [2:0] index;
  logic [31:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface
`default_nettype wire

// ===== design/extended_unicycle_euler_step_core.sv =====
`default_nettype none
// Forward Euler step of a five-state unicycle model (x, y, heading, speed,
// turn rate), all signed Q16.16.
// Channels: in (restart, lin_accel, ang_accel), out (new state, one beat per
// input beat), cfg (index 0 step time, 1..5 initial values; other indices
// ignored). Write cfg only while the core is idle.
// One item at a time: an input beat is taken only when idle. After the accept
// the item passes LOAD, REMAIN, REDUCE (held until the angle lies in [-pi, pi),
// with one more two pi step when the estimated turn count is one period off),
// FOLD, the CORDIC iterations, MUL1..MUL6 and COMMIT, and then out valid is
// raised. After the result beat the core returns to idle before the next
// accept.
// The shared multiplier runs six products in sequence after the CORDIC loop.
// Reset clears the state to zero and step time to 655.
// When the receiver stalls, the result holds on out until taken and no new
// input beat is accepted.
module extended_unicycle_euler_step_core import eues_pkg::*; #(
  parameter int CORDIC_ITERATIONS = CORDIC_ITERATIONS_DEF,
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input wire logic clk,
  input wire logic rst_n,
  eues_in_if.sink in_ch,
  eues_out_if.source out_ch,
  eues_cfg_if.sink cfg_ch
);
  cmd_t cmd;
  stat_t stat;
  logic busy, ov;
  logic in_fire, out_fire, cfg_fire;
  assign in_ch.ready = !busy;
  assign cfg_ch.ready = 1'b1;
  assign in_fire = in_ch.valid && !busy;
  assign out_fire = ov && out_ch.ready;
  assign cfg_fire = cfg_ch.valid;
  assign out_ch.valid = ov;

  eues_ctrl #(.CORDIC_ITERATIONS(CORDIC_ITERATIONS)) u_ctrl (
    .clk, .rst_n, .in_fire, .out_fire, .stat, .cmd, .busy, .out_valid(ov)
  );
  eues_dp #(.FRAC_BITS(FRAC_BITS)) u_dp (
    .clk, .rst_n, .cmd, .stat, .in_fire,
    .in_restart(in_ch.restart), .in_lin_accel(in_ch.lin_accel),
    .in_ang_accel(in_ch.ang_accel), .cfg_fire, .cfg_index(cfg_ch.index),
    .cfg_data(cfg_ch.data), .st_x(out_ch.new_x), .st_y(out_ch.new_y),
    .st_hd(out_ch.new_heading), .st_sp(out_ch.new_speed),
    .st_tr(out_ch.new_turn_rate)
  );
endmodule
`default_nettype wire

// ===== design/eues_ctrl.sv =====
`default_nettype none
module eues_ctrl import eues_pkg::*; #(
  parameter int CORDIC_ITERATIONS = CORDIC_ITERATIONS_DEF
) (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic in_fire,
  input  wire logic out_fire,
  input  wire stat_t stat,
  output cmd_t cmd,
  output logic busy,
  output logic out_valid
);
  localparam int NIT = (CORDIC_ITERATIONS > ATAN_ENTRIES) ? ATAN_ENTRIES
                                                          : CORDIC_ITERATIONS;
  state_t state_r, state_nxt;
  logic [4:0] it_r, it_nxt;

  always_comb begin
    state_nxt = state_r;
    it_nxt = it_r;
    case (state_r)
      ST_IDLE: if (in_fire) state_nxt = ST_LOAD;
      ST_LOAD: state_nxt = ST_REMAIN;
      ST_REMAIN: state_nxt = ST_REDUCE;
      ST_REDUCE: if (stat.reduce_done) state_nxt = ST_FOLD;
      ST_FOLD: begin
        state_nxt = ST_CORDIC;
        it_nxt = '0;
      end
      ST_CORDIC: begin
        it_nxt = it_r + 5'd1;
        if (32'(it_r) == NIT - 1) state_nxt = ST_MUL1;
      end
      ST_MUL1: state_nxt = ST_MUL2;
      ST_MUL2: state_nxt = ST_MUL3;
      ST_MUL3: state_nxt = ST_MUL4;
      ST_MUL4: state_nxt = ST_MUL5;
      ST_MUL5: state_nxt = ST_MUL6;
      ST_MUL6: state_nxt = ST_COMMIT;
      ST_COMMIT: state_nxt = ST_OUT;
      ST_OUT: if (out_fire) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd = '0;
    busy = (state_r != ST_IDLE);
    out_valid = (state_r == ST_OUT);
    case (state_r)
      ST_LOAD: cmd.load = 1'b1;
      ST_REMAIN: cmd.remain = 1'b1;
      ST_REDUCE: cmd.reduce = 1'b1;
      ST_FOLD: cmd.fold = 1'b1;
      ST_CORDIC: cmd.cordic = 1'b1;
      ST_MUL1: begin cmd.mul_en = 1'b1; cmd.mul_step = 3'd0; end
      ST_MUL2: begin cmd.mul_en = 1'b1; cmd.mul_step = 3'd1; end
      ST_MUL3: begin cmd.mul_en = 1'b1; cmd.mul_step = 3'd2; end
      ST_MUL4: begin cmd.mul_en = 1'b1; cmd.mul_step = 3'd3; end
      ST_MUL5: begin cmd.mul_en = 1'b1; cmd.mul_step = 3'd4; end
      ST_MUL6: begin cmd.mul_en = 1'b1; cmd.mul_step = 3'd5; end
      ST_COMMIT: cmd.commit = 1'b1;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      it_r <= '0;
    end else begin
      state_r <= state_nxt;
      it_r <= it_nxt;
    end
  end
endmodule
`default_nettype wire

// ===== design/eues_dp.sv =====
`default_nettype none
module eues_dp import eues_pkg::*; #(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire cmd_t cmd,
  output stat_t stat,
  input  wire logic in_fire,
  input  wire logic in_restart,
  input  wire logic signed [31:0] in_lin_accel,
  input  wire logic signed [31:0] in_ang_accel,
  input  wire logic cfg_fire,
  input  wire logic [2:0] cfg_index,
  input  wire logic [31:0] cfg_data,
  output logic signed [31:0] st_x,
  output logic signed [31:0] st_y,
  output logic signed [31:0] st_hd,
  output logic signed [31:0] st_sp,
  output logic signed [31:0] st_tr
);
  localparam int ASH = 30 - FRAC_BITS;
  localparam int ZW = 34 + ASH;
  localparam int QW = ASH + 2;
  localparam int RSH = 64 - ASH;

  logic [15:0] dt_r;
  logic signed [31:0] ix_r, iy_r, ih_r, is_r, it_r;
  logic signed [31:0] x_r, y_r, h_r, s_r, t_r;
  logic rs_r;
  logic signed [31:0] la_r, aa_r;
  logic signed [35:0] z_r, cx_r, cy_r;
  logic neg_r;
  logic [4:0] i_r;
  logic signed [33:0] dx_r, dy_r, dh_r, ds_r, dtr_r;
  logic signed [33:0] sc_r, ss_r;

  // The number of whole turns is estimated from the heading with a reciprocal
  // multiply and its multiple of two pi removed; the remainder then needs at
  // most one further step of two pi to land in [-pi, pi).
  logic signed [ZW-1:0] zw_r;
  logic signed [QW-1:0] q_r;
  logic signed [31:0] h_sel;
  logic signed [64:0] qprod;
  logic signed [64:0] qrnd;
  logic signed [ZW-1:0] qmul;
  assign h_sel = rs_r ? ih_r : h_r;
  assign qprod = 65'(h_sel) * 65'(signed'({1'b0, INV_TWO_PI_Q64}));
  assign qrnd = (qprod + (65'sd1 <<< (RSH - 1))) >>> RSH;
  assign qmul = ZW'(q_r) * ZW'(TWO_PI_Q30);
  assign stat.reduce_done = (z_r >= -PI_Q30) && (z_r < PI_Q30);

  logic signed [35:0] ysh, xsh;
  assign xsh = cx_r >>> i_r;
  assign ysh = cy_r >>> i_r;

  logic signed [33:0] ma;
  logic signed [36:0] mb;
  logic signed [68:0] prod;
  always_comb begin
    ma = 34'(s_r);
    mb = 37'(cx_r);
    case (cmd.mul_step)
      3'd0: begin ma = 34'(s_r); mb = neg_r ? -37'(cx_r) : 37'(cx_r); end
      3'd1: begin ma = 34'(s_r); mb = 37'(cy_r); end
      3'd2: begin ma = sc_r; mb = 37'(signed'({1'b0, dt_r})); end
      3'd3: begin ma = ss_r; mb = 37'(signed'({1'b0, dt_r})); end
      3'd4: begin ma = 34'(t_r); mb = 37'(signed'({1'b0, dt_r})); end
      3'd5: begin ma = 34'(la_r); mb = 37'(signed'({1'b0, dt_r})); end
      default: ;
    endcase
    prod = 69'(ma) * 69'(mb);
  end
  // speed*cos or speed*sin rounded to the state format
  logic signed [68:0] r30;
  assign r30 = (prod + (69'sd1 <<< 29)) >>> 30;
  logic signed [68:0] r16;
  assign r16 = (prod + 69'sd32768) >>> 16;
  logic signed [47:0] pa;
  assign pa = 48'(aa_r) * 48'(signed'({1'b0, dt_r}));
  logic signed [47:0] ra;
  assign ra = (pa + 48'sd32768) >>> 16;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dt_r <= 16'd655;
      ix_r <= '0; iy_r <= '0; ih_r <= '0; is_r <= '0; it_r <= '0;
      x_r <= '0; y_r <= '0; h_r <= '0; s_r <= '0; t_r <= '0;
    end else begin
      if (cfg_fire) begin
        case (cfg_index)
          REG_STEP_TIME: dt_r <= cfg_data[15:0];
          REG_INIT_X: ix_r <= cfg_data;
          REG_INIT_Y: iy_r <= cfg_data;
          REG_INIT_HD: ih_r <= cfg_data;
          REG_INIT_SP: is_r <= cfg_data;
          REG_INIT_TR: it_r <= cfg_data;
          default: ;
        endcase
      end
      if (cmd.load && rs_r) begin
        x_r <= ix_r; y_r <= iy_r; h_r <= ih_r; s_r <= is_r; t_r <= it_r;
      end
      if (cmd.commit) begin
        x_r <= sat32(34'(x_r) + dx_r);
        y_r <= sat32(34'(y_r) + dy_r);
        h_r <= sat32(34'(h_r) + dh_r);
        s_r <= sat32(34'(s_r) + ds_r);
        t_r <= sat32(34'(t_r) + dtr_r);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      rs_r <= in_restart;
      la_r <= in_lin_accel;
      aa_r <= in_ang_accel;
    end
    if (cmd.load) begin
      zw_r <= ZW'(h_sel) <<< ASH;
      q_r <= QW'(qrnd);
    end
    if (cmd.remain) z_r <= 36'(zw_r - qmul);
    if (cmd.reduce && !stat.reduce_done) z_r <= (z_r < 0) ? z_r + TWO_PI_Q30
                                                           : z_r - TWO_PI_Q30;
    if (cmd.fold) begin
      cx_r <= GAIN_Q30;
      cy_r <= '0;
      i_r <= '0;
      neg_r <= 1'b0;
      if (z_r > HALF_PI_Q30) begin z_r <= z_r - PI_Q30; neg_r <= 1'b1; end
      else if (z_r < -HALF_PI_Q30) begin z_r <= z_r + PI_Q30; neg_r <= 1'b1; end
    end
    if (cmd.cordic) begin
      i_r <= i_r + 5'd1;
      if (z_r >= 0) begin
        cx_r <= cx_r - ysh; cy_r <= cy_r + xsh; z_r <= z_r - atan_q30(i_r);
      end else begin
        cx_r <= cx_r + ysh; cy_r <= cy_r - xsh; z_r <= z_r + atan_q30(i_r);
      end
    end
    if (cmd.mul_en) begin
      case (cmd.mul_step)
        3'd0: begin
          if (neg_r) begin cx_r <= -cx_r; cy_r <= -cy_r; end
          sc_r <= 34'(r30);
        end
        3'd1: ss_r <= 34'(r30);
        3'd2: dx_r <= 34'(r16);
        3'd3: dy_r <= 34'(r16);
        3'd4: dh_r <= 34'(r16);
        3'd5: begin ds_r <= 34'(r16); dtr_r <= 34'(ra); end
        default: ;
      endcase
    end
  end

  assign st_x = x_r; assign st_y = y_r; assign st_hd = h_r;
  assign st_sp = s_r; assign st_tr = t_r;
endmodule
`default_nettype wire

// ===== design/eues_checker.sv =====
`default_nettype none
module eues_checker (
  input wire logic clk,
  input wire logic rst_n,
  input wire logic in_valid,
  input wire logic in_ready,
  input wire logic out_valid,
  input wire logic out_ready,
  input wire logic [31:0] out_x
);
  a_no_in_while_out: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !in_ready) else $error("input taken while result pending");
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_x))
    else $error("result dropped under stall");
  a_no_early: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !out_valid) else $error("result too early");
endmodule

bind extended_unicycle_euler_step_core eues_checker u_chk (
  .clk, .rst_n, .in_valid(in_ch.valid), .in_ready(in_ch.ready),
  .out_valid(out_ch.valid), .out_ready(out_ch.ready), .out_x(out_ch.new_x)
);
`default_nettype wire

// ===== bench/tb_extended_unicycle_euler_step_core.sv =====
`default_nettype none
module tb_extended_unicycle_euler_step_core;
  timeunit 1ns;
  timeprecision 1ps;
  import eues_pkg::*;

  localparam int TURNS = 16;
  localparam int WATCHDOG_LIMIT = 60000;
  localparam int SETTLE_CYCLES = 80;
  localparam logic [2:0] REG_SPARE_A = 3'd6;
  localparam logic [2:0] REG_SPARE_B = 3'd7;
  localparam longint HEADING_SCALE = 64'sd16384;

  typedef struct packed {
    logic restart;
    logic signed [31:0] lin_accel;
    logic signed [31:0] ang_accel;
  } cmd_beat_t;

  typedef struct packed {
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic signed [31:0] heading;
    logic signed [31:0] speed;
    logic signed [31:0] turn_rate;
  } vehicle_state_t;

  logic clk;
  logic rst_n;

  eues_in_if in_ch();
  eues_out_if out_ch();
  eues_cfg_if cfg_ch();

  extended_unicycle_euler_step_core u_top (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch.sink), .out_ch(out_ch.source), .cfg_ch(cfg_ch.sink)
  );

  initial clk = 1'b0;
  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Vehicle model kept by the bench, with its own register copy.
  logic [15:0] dt_reg;
  logic signed [31:0] init_reg [1:5];
  vehicle_state_t veh;

  longint arctan_tab [0:29] = '{
    843314856, 497837829, 263043836, 133525158, 67021686,
    33543515, 16775850, 8388437, 4194282, 2097149,
    1048575, 524287, 262143, 131071, 65535,
    32767, 16383, 8191, 4095, 2047,
    1023, 511, 255, 127, 63, 31, 15, 7, 3, 1};

  cmd_beat_t pending_cmds[$];
  vehicle_state_t expected_states[$];
  int mismatches;
  int watchdog;
  logic in_taken;
  logic out_taken;
  logic fast_send;
  logic fast_recv;
  int send_gap;
  int recv_gap;

  function automatic longint round_shift(longint v, int s);
    return (v + (64'sd1 <<< (s - 1))) >>> s;
  endfunction

  function automatic logic signed [31:0] clamp32(longint v);
    if (v > 64'sd2147483647) return 32'sh7fffffff;
    if (v < -64'sd2147483648) return 32'sh80000000;
    return v[31:0];
  endfunction

  function automatic void heading_sincos(longint hd, output longint c, output longint s);
    longint z, m, x, y, nx;
    logic flip;
    z = hd * HEADING_SCALE;
    m = (z + PI_Q30) % TWO_PI_Q30;
    if (m < 0) m += TWO_PI_Q30;
    z = m - PI_Q30;
    flip = 1'b0;
    // Fold into the right half plane; a half turn negates both components.
    if (z > HALF_PI_Q30) begin
      z -= PI_Q30;
      flip = 1'b1;
    end else if (z < -HALF_PI_Q30) begin
      z += PI_Q30;
      flip = 1'b1;
    end
    x = GAIN_Q30;
    y = 0;
    for (int i = 0; i < TURNS; i++) begin
      if (z >= 0) begin
        nx = x - (y >>> i);
        y = y + (x >>> i);
        z -= arctan_tab[i];
      end else begin
        nx = x + (y >>> i);
        y = y - (x >>> i);
        z += arctan_tab[i];
      end
      x = nx;
    end
    c = flip ? -x : x;
    s = flip ? -y : y;
  endfunction

  function automatic vehicle_state_t euler_advance(cmd_beat_t cmd);
    longint c, s, dt, spd;
    vehicle_state_t nxt;
    if (cmd.restart) begin
      veh.x = init_reg[1];
      veh.y = init_reg[2];
      veh.heading = init_reg[3];
      veh.speed = init_reg[4];
      veh.turn_rate = init_reg[5];
    end
    dt = longint'(dt_reg);
    spd = longint'(veh.speed);
    heading_sincos(longint'(veh.heading), c, s);
    nxt.x = clamp32(longint'(veh.x) + round_shift(round_shift(spd * c, 30) * dt, 16));
    nxt.y = clamp32(longint'(veh.y) + round_shift(round_shift(spd * s, 30) * dt, 16));
    nxt.heading = clamp32(longint'(veh.heading)
                          + round_shift(longint'(veh.turn_rate) * dt, 16));
    nxt.speed = clamp32(spd + round_shift(longint'(cmd.lin_accel) * dt, 16));
    nxt.turn_rate = clamp32(longint'(veh.turn_rate)
                            + round_shift(longint'(cmd.ang_accel) * dt, 16));
    veh = nxt;
    return nxt;
  endfunction

  function automatic int draw_gap(logic fast);
    return fast ? 0 : int'($urandom_range(0, 11));
  endfunction

  initial begin
    in_ch.valid = 1'b0;
    in_ch.restart = 1'b0;
    in_ch.lin_accel = '0;
    in_ch.ang_accel = '0;
    out_ch.ready = 1'b0;
    cfg_ch.valid = 1'b0;
    cfg_ch.index = REG_STEP_TIME;
    cfg_ch.data = '0;
  end

  // Input driver: holds a beat until taken, then waits its drawn gap; it also paces out ready.
  always @(negedge clk) begin
    if (rst_n) begin
      if (!(in_ch.valid && !in_taken)) begin
        if (send_gap > 0) begin
          in_ch.valid <= 1'b0;
          send_gap <= send_gap - 1;
        end else if (pending_cmds.size() > 0) begin
          cmd_beat_t cmd;
          cmd = pending_cmds.pop_front();
          in_ch.valid <= 1'b1;
          in_ch.restart <= cmd.restart;
          in_ch.lin_accel <= cmd.lin_accel;
          in_ch.ang_accel <= cmd.ang_accel;
          if ($urandom_range(0, 40) == 0) fast_send <= ~fast_send;
          send_gap <= draw_gap(fast_send);
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
      if (out_ch.ready && out_taken) begin
        if ($urandom_range(0, 40) == 0) fast_recv <= ~fast_recv;
        recv_gap <= draw_gap(fast_recv);
        out_ch.ready <= 1'b0;
      end else if (recv_gap > 0) begin
        recv_gap <= recv_gap - 1;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  // Prediction on every accepted command and checking of every result beat, plus a watchdog.
  always @(posedge clk) begin
    in_taken <= in_ch.valid && in_ch.ready;
    out_taken <= out_ch.valid && out_ch.ready;
    if (!rst_n) begin
      watchdog <= 0;
    end else begin
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)
          || (cfg_ch.valid && cfg_ch.ready)) begin
        watchdog <= 0;
      end else begin
        watchdog <= watchdog + 1;
      end
      if (watchdog >= WATCHDOG_LIMIT) begin
        $display("FAILURE");
        $finish;
      end
      if (in_ch.valid && in_ch.ready) begin
        cmd_beat_t cmd;
        cmd.restart = in_ch.restart;
        cmd.lin_accel = in_ch.lin_accel;
        cmd.ang_accel = in_ch.ang_accel;
        expected_states.push_back(euler_advance(cmd));
      end
      if (out_ch.valid && out_ch.ready) begin
        vehicle_state_t got, exp_st;
        got.x = out_ch.new_x;
        got.y = out_ch.new_y;
        got.heading = out_ch.new_heading;
        got.speed = out_ch.new_speed;
        got.turn_rate = out_ch.new_turn_rate;
        if (expected_states.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected result beat %h", got);
        end else begin
          exp_st = expected_states.pop_front();
          if (got !== exp_st) begin
            mismatches++;
            if (mismatches <= 10) begin
              $display("mismatch x %0d/%0d y %0d/%0d hd %0d/%0d sp %0d/%0d tr %0d/%0d",
                       exp_st.x, got.x, exp_st.y, got.y, exp_st.heading, got.heading,
                       exp_st.speed, got.speed, exp_st.turn_rate, got.turn_rate);
            end
          end
        end
      end
    end
  end

  task automatic write_reg(logic [2:0] idx, logic [31:0] val);
    @(negedge clk);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data <= val;
    do @(posedge clk); while (!cfg_ch.ready);
    if (idx == REG_STEP_TIME) dt_reg = val[15:0];
    else if (idx >= REG_INIT_X && idx <= REG_INIT_TR) init_reg[idx] = val;
    @(negedge clk);
    cfg_ch.valid <= 1'b0;
  endtask

  task automatic wait_idle();
    wait (pending_cmds.size() == 0 && expected_states.size() == 0 && !in_ch.valid);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic push_cmd(logic rs, logic [31:0] la, logic [31:0] aa);
    cmd_beat_t cmd;
    cmd.restart = rs;
    cmd.lin_accel = la;
    cmd.ang_accel = aa;
    pending_cmds.push_back(cmd);
  endtask

  function automatic logic [31:0] accel_value();
    if ($urandom_range(0, 5) == 0) return $urandom;
    return 32'(int'($urandom_range(0, 2097151)) - 1048576);
  endfunction

  task automatic random_phase(int n);
    for (int i = 0; i < n; i++) begin
      push_cmd($urandom_range(0, 30) == 0, accel_value(), accel_value());
    end
  endtask

  initial begin
    dt_reg = 16'd655;
    for (int i = 1; i <= 5; i++) init_reg[i] = '0;
    veh = '0;
    mismatches = 0;
    send_gap = 0;
    recv_gap = 0;
    fast_send = 1'b0;
    fast_recv = 1'b0;
    in_taken = 1'b0;
    out_taken = 1'b0;
    rst_n = 1'b0;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Directed: extremes of the accelerations from the reset state.
    push_cmd(1'b0, 32'h7fffffff, 32'h80000000);
    push_cmd(1'b0, 32'h80000000, 32'h7fffffff);
    push_cmd(1'b0, 32'h00010000, 32'hffff0000);
    push_cmd(1'b1, 32'h0, 32'h0);
    wait_idle();

    // Largest step, extreme initial values; speed and heading saturate.
    write_reg(REG_STEP_TIME, 32'h0000ffff);
    write_reg(REG_INIT_X, 32'h7fff0000);
    write_reg(REG_INIT_Y, 32'h80010000);
    write_reg(REG_INIT_HD, 32'h7fffffff);
    write_reg(REG_INIT_SP, 32'h7fffffff);
    write_reg(REG_INIT_TR, 32'h7fffffff);
    push_cmd(1'b1, 32'h7fffffff, 32'h7fffffff);
    push_cmd(1'b0, 32'h7fffffff, 32'h7fffffff);
    push_cmd(1'b0, 32'h80000000, 32'h80000000);
    wait_idle();

    write_reg(REG_INIT_HD, 32'h80000000);
    write_reg(REG_INIT_SP, 32'h80000000);
    write_reg(REG_INIT_TR, 32'h80000000);
    write_reg(REG_INIT_X, 32'h80000000);
    write_reg(REG_INIT_Y, 32'h7fffffff);
    push_cmd(1'b1, 32'h80000000, 32'h0);
    push_cmd(1'b0, 32'h0, 32'h80000000);
    wait_idle();

    // Headings near the fold points of the angle reduction.
    write_reg(REG_INIT_TR, 32'h0);
    write_reg(REG_INIT_SP, 32'h00640000);
    write_reg(REG_INIT_HD, 32'h0001921f);
    push_cmd(1'b1, 32'h0, 32'h0);
    wait_idle();
    write_reg(REG_INIT_HD, 32'h00032440);
    push_cmd(1'b1, 32'h0, 32'h0);
    wait_idle();
    write_reg(REG_INIT_HD, 32'hfffcdbbf);
    push_cmd(1'b1, 32'h0, 32'h0);
    wait_idle();
    write_reg(REG_INIT_HD, 32'hfffe6de1);
    push_cmd(1'b1, 32'h0, 32'h0);
    wait_idle();

    // Zero step: state frozen apart from restarts; spare indices ignored.
    write_reg(REG_STEP_TIME, 32'h0);
    write_reg(REG_SPARE_A, 32'hffffffff);
    write_reg(REG_SPARE_B, 32'h12345678);
    push_cmd(1'b0, 32'h7fffffff, 32'h7fffffff);
    push_cmd(1'b1, 32'h80000000, 32'h1);
    wait_idle();

    // Random phases under several settings.
    for (int ph = 0; ph < 8; ph++) begin
      case (ph)
        0: write_reg(REG_STEP_TIME, 32'd655);
        1: write_reg(REG_STEP_TIME, 32'h0000ffff);
        2: write_reg(REG_STEP_TIME, 32'd1);
        3: write_reg(REG_STEP_TIME, 32'h0);
        default: write_reg(REG_STEP_TIME, {16'h0, 16'($urandom)});
      endcase
      write_reg(REG_INIT_X, $urandom);
      write_reg(REG_INIT_Y, $urandom);
      write_reg(REG_INIT_HD, (ph == 5) ? $urandom : 32'(int'($urandom_range(0, 1600000)) - 800000));
      write_reg(REG_INIT_SP, (ph == 6) ? $urandom : 32'(int'($urandom_range(0, 2000000)) - 1000000));
      write_reg(REG_INIT_TR, (ph == 7) ? $urandom : 32'(int'($urandom_range(0, 400000)) - 200000));
      random_phase(200);
      wait_idle();
    end

    if (mismatches == 0 && expected_states.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end
endmodule
`default_nettype wire
